FILE: src/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg: shared types and constants of the LDA Gibbs topic sampler
// Operation codes, register indexes, controller states and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int WGT_BITS  = 48;
    localparam int FRAC_BITS = 12;

    typedef enum logic [1:0] {
        OP_CORPUS = 2'd0,
        OP_DOC    = 2'd1,
        OP_WORD   = 2'd2,
        OP_SAMPLE = 2'd3
    } op_t;

    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_BETA  = 2'd1;
    localparam logic [1:0] REG_NTOP  = 2'd2;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DEC,
        ST_LDW,
        ST_SCHK,
        ST_RD,
        ST_OPND,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_DCHK,
        ST_DIV,
        ST_ACC,
        ST_THR0,
        ST_THR1,
        ST_SRD,
        ST_SCMP,
        ST_URD1,
        ST_UWR1,
        ST_URD2,
        ST_UWR2
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       clr_step;
        logic       ld_write;
        logic       ldw_write;
        logic       init_loop;
        logic       emit_err;
        logic       opnd;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       dchk;
        logic       div_step;
        logic       acc;
        logic       thr0;
        logic       thr1;
        logic       scan_cmp;
        logic       upd_rd_old;
        logic       upd_wr_dec;
        logic       upd_rd_new;
        logic       upd_wr_inc;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        op_t  op;
        logic sample_err;
        logic div_skip;
        logic div_last;
        logic last_topic;
        logic scan_hit;
    } sts_t;

endpackage

FILE: src/lgs_ram.sv
// ----------------------------------------------------------------------------
// lgs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/lgs_ctrl.sv
// ----------------------------------------------------------------------------
// lgs_ctrl: sequencing controller of the topic sampler
// Walks clearing, loads, the per-topic weight loop, the scan and the
// count update, issuing one command bundle per cycle.
// ----------------------------------------------------------------------------
module lgs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  lgs_pkg::sts_t sts,
    output lgs_pkg::cmd_t cmd
);

    lgs_pkg::state_t state_reg;
    lgs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lgs_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lgs_pkg::ST_CLEAR: if (sts.clear_done) state_next = lgs_pkg::ST_IDLE;
            lgs_pkg::ST_IDLE:  if (start) state_next = lgs_pkg::ST_DEC;
            lgs_pkg::ST_DEC:
            begin
                case (sts.op)
                    lgs_pkg::OP_WORD:   state_next = lgs_pkg::ST_LDW;
                    lgs_pkg::OP_SAMPLE: state_next = lgs_pkg::ST_SCHK;
                    default:            state_next = lgs_pkg::ST_IDLE;
                endcase
            end
            lgs_pkg::ST_LDW:  state_next = lgs_pkg::ST_IDLE;
            lgs_pkg::ST_SCHK:
                state_next = sts.sample_err ? lgs_pkg::ST_IDLE : lgs_pkg::ST_RD;
            lgs_pkg::ST_RD:   state_next = lgs_pkg::ST_OPND;
            lgs_pkg::ST_OPND: state_next = lgs_pkg::ST_MUL0;
            lgs_pkg::ST_MUL0: state_next = lgs_pkg::ST_MUL1;
            lgs_pkg::ST_MUL1: state_next = lgs_pkg::ST_MUL2;
            lgs_pkg::ST_MUL2: state_next = lgs_pkg::ST_MUL3;
            lgs_pkg::ST_MUL3: state_next = lgs_pkg::ST_DCHK;
            lgs_pkg::ST_DCHK:
                state_next = sts.div_skip ? lgs_pkg::ST_ACC : lgs_pkg::ST_DIV;
            lgs_pkg::ST_DIV:
                if (sts.div_last) state_next = lgs_pkg::ST_ACC;
            lgs_pkg::ST_ACC:
                state_next = sts.last_topic ? lgs_pkg::ST_THR0 : lgs_pkg::ST_RD;
            lgs_pkg::ST_THR0: state_next = lgs_pkg::ST_THR1;
            lgs_pkg::ST_THR1: state_next = lgs_pkg::ST_SRD;
            lgs_pkg::ST_SRD:  state_next = lgs_pkg::ST_SCMP;
            lgs_pkg::ST_SCMP:
                state_next = (sts.scan_hit || sts.last_topic) ? lgs_pkg::ST_URD1
                                                               : lgs_pkg::ST_SRD;
            lgs_pkg::ST_URD1: state_next = lgs_pkg::ST_UWR1;
            lgs_pkg::ST_UWR1: state_next = lgs_pkg::ST_URD2;
            lgs_pkg::ST_URD2: state_next = lgs_pkg::ST_UWR2;
            lgs_pkg::ST_UWR2: state_next = lgs_pkg::ST_IDLE;
            default:          state_next = lgs_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            lgs_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
            lgs_pkg::ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            lgs_pkg::ST_DEC:  cmd.ld_write  = 1'b1;
            lgs_pkg::ST_LDW:  cmd.ldw_write = 1'b1;
            lgs_pkg::ST_SCHK:
            begin
                cmd.init_loop = !sts.sample_err;
                cmd.emit_err  = sts.sample_err;
            end
            // tables are read at the loop index here, no command needed
            lgs_pkg::ST_RD:   ;
            lgs_pkg::ST_OPND: cmd.opnd = 1'b1;
            lgs_pkg::ST_MUL0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = 2'd0;
            end
            lgs_pkg::ST_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = 2'd1;
            end
            lgs_pkg::ST_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = 2'd2;
            end
            lgs_pkg::ST_MUL3:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = 2'd3;
            end
            lgs_pkg::ST_DCHK: cmd.dchk = 1'b1;
            lgs_pkg::ST_DIV:  cmd.div_step = 1'b1;
            lgs_pkg::ST_ACC:  cmd.acc = 1'b1;
            lgs_pkg::ST_THR0: cmd.thr0 = 1'b1;
            lgs_pkg::ST_THR1: cmd.thr1 = 1'b1;
            // cumulative weight read at the scan index
            lgs_pkg::ST_SRD:  ;
            lgs_pkg::ST_SCMP: cmd.scan_cmp = 1'b1;
            lgs_pkg::ST_URD1: cmd.upd_rd_old = 1'b1;
            lgs_pkg::ST_UWR1: cmd.upd_wr_dec = 1'b1;
            lgs_pkg::ST_URD2: cmd.upd_rd_new = 1'b1;
            lgs_pkg::ST_UWR2: cmd.upd_wr_inc = 1'b1;
            default:          busy = 1'b1;
        endcase
    end

endmodule

FILE: src/lgs_dpath.sv
// ----------------------------------------------------------------------------
// lgs_dpath: datapath of the topic sampler
// Count tables, operand build, split multiplier, bit-serial divider,
// running sum, threshold, scan and saturating count update.
// ----------------------------------------------------------------------------
module lgs_dpath #(
    parameter int MAX_TOPICS = 64,
    parameter int MAX_WORDS  = 1024,
    parameter int COUNT_BITS = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lgs_pkg::cmd_t cmd,
    output lgs_pkg::sts_t sts,
    input  logic [15:0]   alpha_weight,
    input  logic [15:0]   beta_weight,
    input  logic [6:0]    topic_count,
    input  logic [1:0]    op,
    input  logic [30:0]   doc_id,
    input  logic [9:0]    word_id,
    input  logic [5:0]    topic_index,
    input  logic [23:0]   count_value,
    input  logic          last,
    input  logic [31:0]   random_fraction,
    output logic          done,
    output logic [5:0]    new_topic,
    output logic          status
);

    localparam int CB   = COUNT_BITS;
    localparam int FB   = lgs_pkg::FRAC_BITS;
    localparam int WW   = lgs_pkg::WGT_BITS;
    localparam int TB   = $clog2(MAX_TOPICS);
    localparam int WB   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int KW   = $clog2(MAX_TOPICS + 1);
    localparam int AW   = CB + FB + 1;
    localparam int DW   = (((CB + FB) > 27) ? (CB + FB) : 27) + 1;
    localparam int PRW  = (((2 * AW) > WW) ? (2 * AW) : WW) + 1;
    localparam int HW   = (AW + 1) / 2;
    localparam int HIW  = PRW - WW;
    localparam int CMW  = (HIW > DW) ? HIW : DW;
    localparam int DCW  = $clog2(WW);
    localparam int SWB  = WB + TB;
    localparam int TDEP = 1 << TB;

    localparam logic [WW-1:0]  W_MAX   = {WW{1'b1}};
    localparam logic [CB-1:0]  CNT_MAX = {CB{1'b1}};
    localparam logic [DCW-1:0] DIV_TOP = DCW'(WW - 1);

    // captured item
    lgs_pkg::op_t   op_reg;
    logic [30:0]    doc_reg;
    logic [WB-1:0]  word_reg;
    logic [TB-1:0]  topic_reg;
    logic [CB-1:0]  cnt_reg;
    logic           last_reg;
    logic [31:0]    r_reg;
    logic           ldok_reg;
    logic           wok_reg;
    logic           err_reg;
    logic [KW-1:0]  k_reg;

    // loop and arithmetic
    logic [KW-1:0]  i_reg;
    logic [TB-1:0]  pick_reg;
    logic [DW-1:0]  kbeta_reg;
    logic [AW-1:0]  a_reg;
    logic [AW-1:0]  b_reg;
    logic [DW-1:0]  d_reg;
    logic [PRW-1:0] prod_reg;
    logic [DW-1:0]  rem_reg;
    logic [WW-1:0]  lo_reg;
    logic [WW-1:0]  q_reg;
    logic [DCW-1:0] dcnt_reg;
    logic [WW-1:0]  sum_reg;
    logic [63:0]    plo_reg;
    logic [WW-1:0]  thr_reg;

    // control state
    logic [SWB-1:0] clr_reg;
    logic [30:0]    held_doc_reg;
    logic           doc_valid_reg;
    logic           done_reg;
    logic [5:0]     new_topic_reg;
    logic           status_reg;

    // memory ports
    logic [CB-1:0]  corp_rd;
    logic [CB-1:0]  doc_rd;
    logic [CB-1:0]  wt_rd;
    logic           ldd_rd;
    logic [WW-1:0]  cum_rd;
    logic           corp_we;
    logic           doc_we;
    logic           wt_we;
    logic           ldd_we;
    logic [CB-1:0]  corp_wd;
    logic [CB-1:0]  doc_wd;
    logic [CB-1:0]  wt_wd;
    logic           ldd_wd;
    logic [TB-1:0]  wa_topic;
    logic [TB-1:0]  ra_topic;
    logic [TB-1:0]  idx;
    logic [SWB-1:0] wt_waddr;
    logic [WB-1:0]  ldd_waddr;

    // combinational helpers
    int             kint;
    logic           is_cur;
    logic [CB-1:0]  ndz;
    logic [CB-1:0]  nwz;
    logic [CB-1:0]  nz;
    logic [HW-1:0]  ma;
    logic [HW-1:0]  mb;
    logic [2*HW-1:0] pp;
    logic [PRW-1:0] ppx;
    logic [CMW-1:0] hi_ext;
    logic [DW:0]    rem2;
    logic           ge;
    logic [WW:0]    sum_wide;
    logic [WW-1:0]  sum_next;
    logic           doc_skip;

    function automatic logic [CB-1:0] dec_sat(input logic [CB-1:0] v);
        dec_sat = (v == '0) ? v : v - 1'b1;
    endfunction

    function automatic logic [CB-1:0] inc_sat(input logic [CB-1:0] v);
        inc_sat = (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    assign idx = i_reg[TB-1:0];

    // topics in use, clamped to the supported range
    always_comb
    begin
        if (topic_count < 7'd2)
        begin
            kint = 2;
        end
        else if (int'(topic_count) > MAX_TOPICS)
        begin
            kint = MAX_TOPICS;
        end
        else
        begin
            kint = int'(topic_count);
        end
    end

    // capture the item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= lgs_pkg::op_t'(op);
            doc_reg   <= doc_id;
            word_reg  <= WB'(word_id);
            topic_reg <= TB'(topic_index);
            cnt_reg   <= CB'(count_value);
            last_reg  <= last;
            r_reg     <= random_fraction;
            ldok_reg  <= int'(topic_index) < MAX_TOPICS;
            wok_reg   <= int'(word_id) < MAX_WORDS;
            err_reg   <= (int'(topic_index) >= kint) || (int'(word_id) >= MAX_WORDS);
            k_reg     <= KW'(kint);
        end
    end

    // operands with the token removed at its current topic
    always_comb
    begin
        is_cur = (idx == topic_reg);
        ndz    = is_cur ? dec_sat(doc_rd)  : doc_rd;
        nwz    = is_cur ? dec_sat(wt_rd)   : wt_rd;
        nz     = is_cur ? dec_sat(corp_rd) : corp_rd;
    end

    // one partial product per cycle
    always_comb
    begin
        ma  = cmd.mul_sel[1] ? HW'(a_reg[AW-1:HW]) : a_reg[HW-1:0];
        mb  = cmd.mul_sel[0] ? HW'(b_reg[AW-1:HW]) : b_reg[HW-1:0];
        pp  = (2*HW)'(ma) * (2*HW)'(mb);
        case (cmd.mul_sel)
            2'd0:    ppx = PRW'(pp);
            2'd3:    ppx = PRW'(pp) << (2 * HW);
            default: ppx = PRW'(pp) << HW;
        endcase
    end

    // divider and running sum
    always_comb
    begin
        hi_ext   = CMW'(prod_reg[PRW-1:WW]);
        rem2     = {rem_reg, lo_reg[WW-1]};
        ge       = rem2 >= {1'b0, d_reg};
        sum_wide = {1'b0, sum_reg} + {1'b0, q_reg};
        sum_next = sum_wide[WW] ? W_MAX : sum_wide[WW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_loop)
        begin
            i_reg     <= '0;
            sum_reg   <= '0;
            kbeta_reg <= DW'(k_reg * beta_weight);
        end
        if (cmd.opnd)
        begin
            a_reg <= (AW'(ndz) << FB) + AW'(alpha_weight);
            b_reg <= (AW'(nwz) << FB) + AW'(beta_weight);
            d_reg <= (DW'(nz) << FB) + kbeta_reg;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= (cmd.mul_sel == 2'd0) ? ppx : prod_reg + ppx;
        end
        if (cmd.dchk)
        begin
            rem_reg  <= DW'(prod_reg[PRW-1:WW]);
            lo_reg   <= prod_reg[WW-1:0];
            dcnt_reg <= DIV_TOP;
            if (d_reg == '0)
            begin
                q_reg <= '0;
            end
            else if (hi_ext >= CMW'(d_reg))
            begin
                q_reg <= W_MAX;
            end
            else
            begin
                q_reg <= '0;
            end
        end
        if (cmd.div_step)
        begin
            rem_reg  <= ge ? DW'(rem2 - {1'b0, d_reg}) : DW'(rem2);
            q_reg    <= {q_reg[WW-2:0], ge};
            lo_reg   <= {lo_reg[WW-2:0], 1'b0};
            dcnt_reg <= dcnt_reg - 1'b1;
        end
        if (cmd.acc)
        begin
            sum_reg <= sum_next;
            i_reg   <= i_reg + 1'b1;
        end
        if (cmd.thr0)
        begin
            plo_reg <= 64'(r_reg) * 64'(sum_reg[31:0]);
        end
        if (cmd.thr1)
        begin
            thr_reg <= WW'(r_reg) * WW'(sum_reg[WW-1:32]) + WW'(plo_reg[63:32]);
            i_reg   <= '0;
        end
        if (cmd.scan_cmp)
        begin
            pick_reg <= idx;
            if (!(cum_rd > thr_reg))
            begin
                i_reg <= i_reg + 1'b1;
            end
        end
    end

    // held document, clearing sweep and result strobe
    assign doc_skip = doc_valid_reg && (held_doc_reg == doc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            held_doc_reg  <= '0;
            doc_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            new_topic_reg <= '0;
            status_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.ld_write && (op_reg == lgs_pkg::OP_DOC) && ldok_reg && !doc_skip
                && last_reg)
            begin
                held_doc_reg  <= doc_reg;
                doc_valid_reg <= 1'b1;
            end
            if (cmd.emit_err)
            begin
                done_reg      <= 1'b1;
                new_topic_reg <= '0;
                status_reg    <= 1'b1;
            end
            if (cmd.upd_wr_inc)
            begin
                done_reg      <= 1'b1;
                new_topic_reg <= 6'(pick_reg);
                status_reg    <= 1'b0;
            end
        end
    end

    // table addressing
    always_comb
    begin
        if (cmd.upd_rd_new)
        begin
            ra_topic = pick_reg;
        end
        else if (cmd.upd_rd_old)
        begin
            ra_topic = topic_reg;
        end
        else
        begin
            ra_topic = idx;
        end

        if (cmd.clr_step)
        begin
            wa_topic = clr_reg[TB-1:0];
        end
        else if (cmd.upd_wr_inc)
        begin
            wa_topic = pick_reg;
        end
        else
        begin
            wa_topic = topic_reg;
        end

        wt_waddr  = cmd.clr_step ? clr_reg : {word_reg, wa_topic};
        ldd_waddr = cmd.clr_step ? clr_reg[WB-1:0] : word_reg;

        corp_we = cmd.clr_step || cmd.upd_wr_dec || cmd.upd_wr_inc
                  || (cmd.ld_write && (op_reg == lgs_pkg::OP_CORPUS) && ldok_reg);
        doc_we  = cmd.clr_step || cmd.upd_wr_dec || cmd.upd_wr_inc
                  || (cmd.ld_write && (op_reg == lgs_pkg::OP_DOC) && ldok_reg && !doc_skip);
        wt_we   = cmd.clr_step || cmd.upd_wr_dec || cmd.upd_wr_inc
                  || (cmd.ldw_write && ldok_reg && wok_reg && !ldd_rd);
        ldd_we  = cmd.clr_step || (cmd.ldw_write && ldok_reg && wok_reg && !ldd_rd && last_reg);
        ldd_wd  = !cmd.clr_step;

        if (cmd.clr_step)
        begin
            corp_wd = '0;
            doc_wd  = '0;
            wt_wd   = '0;
        end
        else if (cmd.upd_wr_dec)
        begin
            corp_wd = dec_sat(corp_rd);
            doc_wd  = dec_sat(doc_rd);
            wt_wd   = dec_sat(wt_rd);
        end
        else if (cmd.upd_wr_inc)
        begin
            corp_wd = inc_sat(corp_rd);
            doc_wd  = inc_sat(doc_rd);
            wt_wd   = inc_sat(wt_rd);
        end
        else
        begin
            corp_wd = cnt_reg;
            doc_wd  = cnt_reg;
            wt_wd   = cnt_reg;
        end
    end

    lgs_ram #(.WIDTH(CB), .DEPTH(TDEP)) u_corpus (
        .clk   (clk),
        .we    (corp_we),
        .waddr (wa_topic),
        .wdata (corp_wd),
        .raddr (ra_topic),
        .rdata (corp_rd)
    );

    lgs_ram #(.WIDTH(CB), .DEPTH(TDEP)) u_doc (
        .clk   (clk),
        .we    (doc_we),
        .waddr (wa_topic),
        .wdata (doc_wd),
        .raddr (ra_topic),
        .rdata (doc_rd)
    );

    lgs_ram #(.WIDTH(CB), .DEPTH(1 << SWB)) u_word_topic (
        .clk   (clk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (wt_wd),
        .raddr ({word_reg, ra_topic}),
        .rdata (wt_rd)
    );

    lgs_ram #(.WIDTH(1), .DEPTH(1 << WB)) u_loaded (
        .clk   (clk),
        .we    (ldd_we),
        .waddr (ldd_waddr),
        .wdata (ldd_wd),
        .raddr (word_reg),
        .rdata (ldd_rd)
    );

    lgs_ram #(.WIDTH(WW), .DEPTH(TDEP)) u_cum (
        .clk   (clk),
        .we    (cmd.acc),
        .waddr (idx),
        .wdata (sum_next),
        .raddr (idx),
        .rdata (cum_rd)
    );

    // status toward the controller
    assign sts.clear_done = &clr_reg;
    assign sts.op         = op_reg;
    assign sts.sample_err = err_reg;
    assign sts.div_skip   = (d_reg == '0) || (hi_ext >= CMW'(d_reg));
    assign sts.div_last   = (dcnt_reg == '0);
    assign sts.last_topic = (i_reg == k_reg - 1'b1);
    assign sts.scan_hit   = cum_rd > thr_reg;

    assign done      = done_reg;
    assign new_topic = new_topic_reg;
    assign status    = status_reg;

endmodule

FILE: src/lda_gibbs_topic_sampler_unit.sv
// ----------------------------------------------------------------------------
// lda_gibbs_topic_sampler_unit: collapsed Gibbs topic sampler for LDA
// One word at a time: a new command is accepted only once the unit is idle;
// an out-of-range sample is answered with an error result, and a sample
// runs the weight loop over the K topics in use, then scans the cumulative
// weights; a topic whose divide is skipped (saturated weight or zero divisor) bypasses the bit-serial divider.
// The result strobe cannot be stalled. Reset: a clearing pass over the count,
// word-topic and loaded tables, busy high.
// ----------------------------------------------------------------------------
module lda_gibbs_topic_sampler_unit #(
    parameter int MAX_TOPICS = 64,
    parameter int MAX_WORDS  = 1024,
    parameter int COUNT_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [30:0] doc_id,
    input  logic [9:0]  word_id,
    input  logic [5:0]  topic_index,
    input  logic [23:0] count_value,
    input  logic        last,
    input  logic [31:0] random_fraction,
    // result word, one cycle per strobe
    output logic        done,
    output logic [5:0]  new_topic,
    output logic        status,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]   alpha_reg;
    logic [15:0]   beta_reg;
    logic [6:0]    ntop_reg;
    logic          cfg_wr;
    lgs_pkg::cmd_t cmd;
    lgs_pkg::sts_t sts;

    // Registers take a write in the access phase; the port never waits.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= 16'd410;
            beta_reg  <= 16'd41;
            ntop_reg  <= 7'd64;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                lgs_pkg::REG_ALPHA: alpha_reg <= pwdata[15:0];
                lgs_pkg::REG_BETA:  beta_reg  <= pwdata[15:0];
                lgs_pkg::REG_NTOP:  ntop_reg  <= pwdata[6:0];
                default:            ;
            endcase
        end
    end

    // Read back: unused addresses return zero.
    always_comb
    begin
        unique case (paddr[3:2])
            lgs_pkg::REG_ALPHA: prdata = {16'd0, alpha_reg};
            lgs_pkg::REG_BETA:  prdata = {16'd0, beta_reg};
            lgs_pkg::REG_NTOP:  prdata = {25'd0, ntop_reg};
            default:            prdata = '0;
        endcase
    end

    // Controller: sequences clearing, loads, weight loop, scan and update.
    lgs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Datapath: count tables, weight arithmetic and the result word.
    lgs_dpath #(
        .MAX_TOPICS (MAX_TOPICS),
        .MAX_WORDS  (MAX_WORDS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .alpha_weight    (alpha_reg),
        .beta_weight     (beta_reg),
        .topic_count     (ntop_reg),
        .op              (op),
        .doc_id          (doc_id),
        .word_id         (word_id),
        .topic_index     (topic_index),
        .count_value     (count_value),
        .last            (last),
        .random_fraction (random_fraction),
        .done            (done),
        .new_topic       (new_topic),
        .status          (status)
    );

endmodule
